// ----- hw/rtl/feeder_encoder_position_stop_core_macros.svh -----
// Assertion macros used by the feeder position stop top level
`ifndef FEEDER_ENCODER_POSITION_STOP_CORE_MACROS_SVH
`define FEEDER_ENCODER_POSITION_STOP_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FEPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define FEPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/feps_pkg.sv -----
// Types and constants of the feeder position stop block
`default_nettype none

package feps_pkg;

	typedef enum logic [2:0] {
		OP_EDGE_A   = 3'd0,
		OP_EDGE_B   = 3'd1,
		OP_FORWARD  = 3'd2,
		OP_BACKWARD = 3'd3,
		OP_BRAKE    = 3'd4,
		OP_RELEASE  = 3'd5,
		OP_ENABLE   = 3'd6,
		OP_DISABLE  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		CH_NONE = 2'd0,
		CH_A    = 2'd1,
		CH_B    = 2'd2
	} chan_t;

	typedef enum logic {
		DIR_FWD = 1'b0,
		DIR_BWD = 1'b1
	} dir_t;

	typedef enum logic {
		REG_SCALE_NUM = 1'b0,
		REG_SCALE_DEN = 1'b1
	} reg_idx_t;

	// driver pin levels
	typedef struct packed {
		logic en;
		logic fwd;
		logic rev;
	} pins_t;

	localparam int SCALE_WIDTH = 16;
	localparam int DIST_WIDTH  = 8;
	localparam int MAIN_WIDTH  = 32;
	localparam int TGT_OUT_WIDTH = 24;

	localparam logic [SCALE_WIDTH-1:0] NUM_RESET = 16'd112;
	localparam logic [SCALE_WIDTH-1:0] DEN_RESET = 16'd41895;

endpackage

`default_nettype wire

// ----- hw/rtl/feps_in_if.sv -----
// Input event channel
`default_nettype none

interface feps_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] distance;

	modport source (output valid, op, distance, input ready);
	modport sink   (input valid, op, distance, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/feps_out_if.sv -----
// Result channel
`default_nettype none

interface feps_out_if;
	logic               valid;
	logic               ready;
	logic               drive_enable;
	logic               fwd_drive;
	logic               rev_drive;
	logic signed [31:0] main_count;
	logic signed [31:0] aux_count;
	logic signed [23:0] target_mm;
	logic               reached;

	modport source (output valid, drive_enable, fwd_drive, rev_drive, main_count,
		aux_count, target_mm, reached, input ready);
	modport sink   (input valid, drive_enable, fwd_drive, rev_drive, main_count,
		aux_count, target_mm, reached, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/feps_cfg_if.sv -----
// Register write channel
`default_nettype none

interface feps_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/feps_step.sv -----
// Next-state logic for one event: counts, target, stop compare and pin levels
`default_nettype none

module feps_step #(
	parameter int COUNT_WIDTH  = 32,
	parameter int TARGET_WIDTH = 24
) (
	input  feps_pkg::op_t                  op,
	input  logic [7:0]                     move_mm,
	input  logic [15:0]                    num,
	input  logic [15:0]                    den,
	input  logic [COUNT_WIDTH-1:0]         pulse,
	input  logic [COUNT_WIDTH-1:0]         second,
	input  feps_pkg::chan_t                last_ch,
	input  feps_pkg::dir_t                 dir,
	input  logic signed [TARGET_WIDTH-1:0] target,
	input  feps_pkg::pins_t                pins,
	output logic [COUNT_WIDTH-1:0]         pulse_d,
	output logic [COUNT_WIDTH-1:0]         second_d,
	output feps_pkg::chan_t                last_ch_d,
	output feps_pkg::dir_t                 dir_d,
	output logic signed [TARGET_WIDTH-1:0] target_d,
	output feps_pkg::pins_t                pins_d,
	output logic                           reached_d
);
	import feps_pkg::*;

	// wide enough for count*num, target*den and one extra step either way
	localparam int MW = ((COUNT_WIDTH > TARGET_WIDTH) ? COUNT_WIDTH : TARGET_WIDTH) + 18;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic signed [TARGET_WIDTH-1:0] TGT_MAX = {1'b0, {(TARGET_WIDTH-1){1'b1}}};
	localparam logic signed [TARGET_WIDTH-1:0] TGT_MIN = {1'b1, {(TARGET_WIDTH-1){1'b0}}};

	logic signed [MW-1:0] num_s, den_s, dd_s;
	logic signed [MW-1:0] pos_sc, tgt_sc, pos_a;
	logic signed [MW-1:0] tgt_up_sc, tgt_dn_sc;
	logic [COUNT_WIDTH-1:0] pulse_a, second_b;
	logic signed [TARGET_WIDTH:0] tsum_up, tsum_dn;
	logic ovf_up, ovf_dn, wrap_up, wrap_dn, stop_a;
	logic signed [TARGET_WIDTH-1:0] tgt_up, tgt_dn;

	always_comb begin
		num_s  = MW'(num);
		den_s  = MW'(den);
		dd_s   = MW'(move_mm) * den_s;
		pos_sc = MW'($signed(pulse)) * num_s;
		tgt_sc = MW'(target) * den_s;

		// position after a counted A edge, the product carried along instead of redone
		wrap_up = (pulse == CNT_MAX);
		wrap_dn = (pulse == CNT_MIN);
		if (dir == DIR_FWD) begin
			pulse_a = pulse + 1'b1;
			pos_a   = wrap_up ? -(num_s <<< (COUNT_WIDTH-1)) : pos_sc + num_s;
		end else begin
			pulse_a = pulse - 1'b1;
			pos_a   = wrap_dn ? (num_s <<< (COUNT_WIDTH-1)) - num_s : pos_sc - num_s;
		end
		second_b = (dir == DIR_FWD) ? second + 1'b1 : second - 1'b1;
		stop_a = (dir == DIR_FWD) ? (pos_a >= tgt_sc) : (pos_a <= tgt_sc);

		// saturating target moves
		tsum_up = {target[TARGET_WIDTH-1], target} + (TARGET_WIDTH+1)'(move_mm);
		tsum_dn = {target[TARGET_WIDTH-1], target} - (TARGET_WIDTH+1)'(move_mm);
		ovf_up  = tsum_up[TARGET_WIDTH] != tsum_up[TARGET_WIDTH-1];
		ovf_dn  = tsum_dn[TARGET_WIDTH] != tsum_dn[TARGET_WIDTH-1];
		tgt_up  = ovf_up ? TGT_MAX : tsum_up[TARGET_WIDTH-1:0];
		tgt_dn  = ovf_dn ? TGT_MIN : tsum_dn[TARGET_WIDTH-1:0];
		tgt_up_sc = ovf_up ? (den_s <<< (TARGET_WIDTH-1)) - den_s : tgt_sc + dd_s;
		tgt_dn_sc = ovf_dn ? -(den_s <<< (TARGET_WIDTH-1)) : tgt_sc - dd_s;

		pulse_d   = pulse;
		second_d  = second;
		last_ch_d = last_ch;
		dir_d     = dir;
		target_d  = target;
		pins_d    = pins;
		reached_d = 1'b0;

		case (op)
			OP_EDGE_A: begin
				if (last_ch != CH_A) begin
					last_ch_d = CH_A;
					pulse_d   = pulse_a;
					if (stop_a) begin
						pins_d.fwd = 1'b1;
						pins_d.rev = 1'b1;
						reached_d  = 1'b1;
					end
				end
			end
			OP_EDGE_B: begin
				if (last_ch != CH_B) begin
					last_ch_d = CH_B;
					second_d  = second_b;
				end
			end
			OP_FORWARD: begin
				dir_d    = DIR_FWD;
				target_d = tgt_up;
				if (tgt_up_sc > pos_sc) begin
					pins_d.fwd = 1'b1;
					pins_d.rev = 1'b0;
				end
			end
			OP_BACKWARD: begin
				dir_d    = DIR_BWD;
				target_d = tgt_dn;
				if (tgt_dn_sc < pos_sc) begin
					pins_d.fwd = 1'b0;
					pins_d.rev = 1'b1;
				end
			end
			OP_BRAKE: begin
				pins_d.fwd = 1'b1;
				pins_d.rev = 1'b1;
			end
			OP_RELEASE: begin
				pins_d.fwd = 1'b0;
				pins_d.rev = 1'b0;
			end
			OP_ENABLE: begin
				pins_d = '{en: 1'b1, fwd: 1'b0, rev: 1'b0};
			end
			default: begin
				pins_d.en = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/feeder_encoder_position_stop_core.sv -----
// Top level of the tape feeder motor position stop block
// Takes one event beat per cycle (hall edge A or B, move, brake, release, enable,
// disable) and returns one result beat per event, registered: the result shows in the
// cycle after its event is taken, and a new event is taken in that same cycle unless
// the result is stalled. The rate is set by the combinational next-state path, where
// count*scale_num and target*scale_den are formed in parallel from the stored state
// and compared. An A edge on a channel other than the last counted one steps the count
// and brakes the bridge once the position reaches the target in the current direction.
// Scale register writes take effect for the next event; the write channel never stalls.
`default_nettype none

module feeder_encoder_position_stop_core #(
	parameter int COUNT_WIDTH  = 32,
	parameter int TARGET_WIDTH = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	feps_in_if.sink    req,
	feps_out_if.source rsp,
	feps_cfg_if.sink   cfg
);
	import feps_pkg::*;

	`include "feeder_encoder_position_stop_core_macros.svh"

	logic [15:0] num_q, den_q;
	logic [COUNT_WIDTH-1:0] pulse_q, second_q, pulse_d, second_d;
	chan_t last_ch_q, last_ch_d;
	dir_t dir_q, dir_d;
	logic signed [TARGET_WIDTH-1:0] target_q, target_d;
	pins_t pins_q, pins_d;
	logic reached_d;

	logic out_valid_q, reached_q;
	pins_t out_pins_q;
	logic [MAIN_WIDTH-1:0] main_q, aux_q;
	logic [TGT_OUT_WIDTH-1:0] tgt_out_q;
	logic [MAIN_WIDTH-1:0] tgt_ext;
	logic acc;

	assign req.ready = !out_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	feps_step #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TARGET_WIDTH(TARGET_WIDTH)
	) u_step (
		.op       (op_t'(req.op)),
		.move_mm  (req.distance),
		.num      (num_q),
		.den      (den_q),
		.pulse    (pulse_q),
		.second   (second_q),
		.last_ch  (last_ch_q),
		.dir      (dir_q),
		.target   (target_q),
		.pins     (pins_q),
		.pulse_d  (pulse_d),
		.second_d (second_d),
		.last_ch_d(last_ch_d),
		.dir_d    (dir_d),
		.target_d (target_d),
		.pins_d   (pins_d),
		.reached_d(reached_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_RESET;
			den_q <= DEN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_idx_t'(cfg.index))
				REG_SCALE_NUM: num_q <= cfg.data;
				REG_SCALE_DEN: den_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q     <= '0;
			second_q    <= '0;
			last_ch_q   <= CH_NONE;
			dir_q       <= DIR_FWD;
			target_q    <= '0;
			pins_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				pulse_q   <= pulse_d;
				second_q  <= second_d;
				last_ch_q <= last_ch_d;
				dir_q     <= dir_d;
				target_q  <= target_d;
				pins_q    <= pins_d;
			end
			if (acc)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			out_pins_q <= pins_d;
			main_q     <= MAIN_WIDTH'($signed(pulse_d));
			aux_q      <= MAIN_WIDTH'($signed(second_d));
			tgt_out_q  <= tgt_ext[TGT_OUT_WIDTH-1:0];
			reached_q  <= reached_d;
		end
	end

	assign tgt_ext = MAIN_WIDTH'(target_d);

	assign rsp.valid        = out_valid_q;
	assign rsp.drive_enable = out_pins_q.en;
	assign rsp.fwd_drive    = out_pins_q.fwd;
	assign rsp.rev_drive    = out_pins_q.rev;
	assign rsp.main_count   = main_q;
	assign rsp.aux_count    = aux_q;
	assign rsp.target_mm    = tgt_out_q;
	assign rsp.reached      = reached_q;

	`FEPS_ASSERT_NEXT(a_beat_out, acc, out_valid_q, "accepted event beat gave no result beat")
	`FEPS_ASSERT_SAME(a_reach_brakes, out_valid_q && reached_q,
		out_pins_q.fwd && out_pins_q.rev, "reached without brake levels")
	`FEPS_ASSERT_NEXT(a_reach_only_a, acc && (op_t'(req.op) != OP_EDGE_A), !reached_q,
		"reached flagged on an event other than an A edge")
	`FEPS_ASSERT_NEXT(a_repeat_a, acc && (op_t'(req.op) == OP_EDGE_A) && (last_ch_q == CH_A),
		$stable(pulse_q), "repeated A edge moved the count")

endmodule

`default_nettype wire
